>>> rtl/core/bdsr_pkg.sv
// shared types and constants for the bridge adc serial reader
`timescale 1ns / 1ps
`default_nettype none

package bdsr_pkg;

    localparam int SUM_W  = 32;   // running sum of sign-extended conversions
    localparam int TICK_W = 24;   // tick counters and timing registers
    localparam int CNT_W  = 8;    // conversion counts
    localparam int AVG_W  = 24;   // averaged result
    localparam int ACT_W  = 2;
    localparam int IDX_W  = 2;

    // action codes on the input word
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESET = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SETTLE   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_RST_HIGH = 2'd2;
    localparam logic [IDX_W-1:0] CFG_RST_LOW  = 2'd3;

    // configuration reset values
    localparam logic [TICK_W-1:0] RST_TIMEOUT  = 24'd100000;
    localparam logic [CNT_W-1:0]  RST_SETTLE   = 8'd3;
    localparam logic [TICK_W-1:0] RST_RST_HIGH = 24'd1000;
    localparam logic [TICK_W-1:0] RST_RST_LOW  = 24'd500000;

    typedef struct packed {
        logic [TICK_W-1:0] timeout;
        logic [CNT_W-1:0]  settle;
        logic [TICK_W-1:0] rst_high;
        logic [TICK_W-1:0] rst_low;
    } t_cfg;

    // what one tick of the sequencer produces
    typedef struct packed {
        logic              clock_pin;
        logic              busy;
        logic              done;
        logic              success;
        logic              div_go;    // average needs the divider
        logic [SUM_W-1:0]  div_sum;
        logic [CNT_W-1:0]  div_cnt;
    } t_tick_res;

endpackage

`default_nettype wire

>>> rtl/core/bdsr_div.sv
// serial restoring divider: signed sum over conversion count, truncating toward zero
`timescale 1ns / 1ps
`default_nettype none

module bdsr_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [bdsr_pkg::SUM_W-1:0]   i_sum,
    input  wire logic [bdsr_pkg::CNT_W-1:0]   i_divisor,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [bdsr_pkg::AVG_W-1:0]        o_quot
);

    localparam int SUM_W  = bdsr_pkg::SUM_W;
    localparam int CNT_W  = bdsr_pkg::CNT_W;
    localparam int AVG_W  = bdsr_pkg::AVG_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_ABS,
        D_RUN,
        D_DONE
    } t_dstate;

    t_dstate            r_state, n_state;
    logic [SUM_W-1:0]   r_num, n_num;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]   r_div, n_div;
    logic               r_neg, n_neg;
    logic [STEP_W-1:0]  r_step, n_step;

    logic [CNT_W:0]     shifted;
    logic               fits;

    // one quotient bit per cycle
    assign shifted = {r_rem, r_num[SUM_W-1]};
    assign fits    = shifted >= {1'b0, r_div};

    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_rem   = r_rem;
        n_div   = r_div;
        n_neg   = r_neg;
        n_step  = r_step;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_num   = i_sum;
                    n_neg   = i_sum[SUM_W-1];
                    n_div   = i_divisor;
                    n_state = D_ABS;
                end
            end
            D_ABS: begin
                n_num   = r_neg ? (~r_num + SUM_W'(1)) : r_num;
                n_rem   = '0;
                n_step  = '0;
                n_state = D_RUN;
            end
            D_RUN: begin
                n_rem  = fits ? CNT_W'(shifted - {1'b0, r_div}) : shifted[CNT_W-1:0];
                n_num  = {r_num[SUM_W-2:0], fits};
                n_step = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_state = D_DONE;
                end
            end
            D_DONE: begin
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    assign o_busy = (r_state != D_IDLE);
    assign o_done = (r_state == D_DONE);
    assign o_quot = r_neg ? ((~r_num[AVG_W-1:0]) + AVG_W'(1)) : r_num[AVG_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/bdsr_seq.sv
// tick sequencer: power-down, ready wait, bit clocking and summing
`timescale 1ns / 1ps
`default_nettype none

module bdsr_seq #(
    parameter int ADC_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [bdsr_pkg::ACT_W-1:0]    i_action,
    input  wire logic [bdsr_pkg::CNT_W-1:0]    i_sample_count,
    input  wire logic                          i_data_pin,
    input  wire bdsr_pkg::t_cfg                i_cfg,
    output bdsr_pkg::t_tick_res                o_res
);

    localparam int SUM_W  = bdsr_pkg::SUM_W;
    localparam int TICK_W = bdsr_pkg::TICK_W;
    localparam int CNT_W  = bdsr_pkg::CNT_W;
    localparam int BIT_CW = $clog2(ADC_BITS + 1);
    localparam int EXT_W  = SUM_W - ADC_BITS;
    localparam logic [BIT_CW-1:0] LAST_BIT = BIT_CW'(ADC_BITS);

    typedef enum logic [2:0] {
        P_IDLE,
        P_RST_HIGH,
        P_RST_LOW,
        P_WAIT,
        P_BIT_HIGH,
        P_BIT_LOW,
        P_END_HIGH,
        P_END_LOW
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [BIT_CW-1:0]    r_bits, n_bits;
    logic [ADC_BITS-1:0]  r_shift, n_shift;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [CNT_W-1:0]     r_good, n_good;
    logic [CNT_W-1:0]     r_wanted, n_wanted;
    logic [CNT_W-1:0]     r_settle, n_settle;
    logic [TICK_W-1:0]    r_wait, n_wait;
    logic                 r_ready, n_ready;
    logic                 r_clk, n_clk;

    logic [TICK_W-1:0]    wait_inc;
    logic [BIT_CW-1:0]    bits_inc;
    logic [CNT_W-1:0]     good_inc;
    logic [CNT_W-1:0]     req_cnt;
    logic [SUM_W-1:0]     raw;
    logic [SUM_W-1:0]     sum_add;
    bdsr_pkg::t_tick_res  res;

    assign wait_inc = r_wait + TICK_W'(1);
    assign bits_inc = r_bits + BIT_CW'(1);
    assign good_inc = r_good + CNT_W'(1);
    assign req_cnt  = (i_sample_count == '0) ? CNT_W'(1) : i_sample_count;
    // sign-extend the finished conversion
    assign raw      = {{EXT_W{r_shift[ADC_BITS-1]}}, r_shift};
    assign sum_add  = r_sum + raw;

    always_comb begin
        n_phase  = r_phase;
        n_bits   = r_bits;
        n_shift  = r_shift;
        n_sum    = r_sum;
        n_good   = r_good;
        n_wanted = r_wanted;
        n_settle = r_settle;
        n_wait   = r_wait;
        n_ready  = r_ready;
        n_clk    = r_clk;
        res      = '0;
        unique case (r_phase)
            P_IDLE: begin
                case (i_action)
                    bdsr_pkg::ACT_START: begin
                        if (!r_ready) begin
                            n_wanted = req_cnt;
                            n_good   = '0;
                            n_sum    = '0;
                            n_settle = '0;
                            n_clk    = 1'b1;
                            n_wait   = TICK_W'(1);
                            n_phase  = P_RST_HIGH;
                        end else begin
                            n_wanted = req_cnt;
                            n_good   = '0;
                            n_sum    = '0;
                            n_clk    = 1'b0;
                            n_wait   = '0;
                            n_bits   = '0;
                            n_shift  = '0;
                            n_phase  = P_WAIT;
                        end
                    end
                    bdsr_pkg::ACT_RESET: begin
                        n_ready  = 1'b0;
                        n_wanted = '0;
                        n_good   = '0;
                        n_sum    = '0;
                        n_settle = '0;
                        n_clk    = 1'b1;
                        n_wait   = TICK_W'(1);
                        n_phase  = P_RST_HIGH;
                    end
                    default: ;
                endcase
            end
            P_RST_HIGH: begin
                if (r_wait >= i_cfg.rst_high) begin
                    n_clk   = 1'b0;
                    n_wait  = '0;
                    n_phase = P_RST_LOW;
                end else begin
                    n_wait = wait_inc;
                end
            end
            P_RST_LOW: begin
                if (r_wait >= i_cfg.rst_low) begin
                    if (r_wanted == '0) begin
                        // forced reset finished
                        n_phase     = P_IDLE;
                        n_clk       = 1'b0;
                        res.done    = 1'b1;
                        res.success = 1'b1;
                    end else begin
                        n_settle = i_cfg.settle;
                        if (i_cfg.settle == '0) begin
                            n_ready = 1'b1;
                        end
                        n_clk   = 1'b0;
                        n_wait  = '0;
                        n_bits  = '0;
                        n_shift = '0;
                        n_phase = P_WAIT;
                    end
                end else begin
                    n_wait = wait_inc;
                end
            end
            P_WAIT: begin
                if (!i_data_pin) begin
                    n_clk   = 1'b1;
                    n_phase = P_BIT_HIGH;
                end else begin
                    n_wait = wait_inc;
                    if (wait_inc >= i_cfg.timeout) begin
                        n_phase = P_IDLE;
                        n_clk   = 1'b0;
                        if (!r_ready || (r_good == '0)) begin
                            n_ready  = 1'b0;
                            res.done = 1'b1;
                        end else begin
                            res.div_go  = 1'b1;
                            res.div_sum = r_sum;
                            res.div_cnt = r_good;
                        end
                    end
                end
            end
            P_BIT_HIGH: begin
                n_clk   = 1'b0;
                n_phase = P_BIT_LOW;
            end
            P_BIT_LOW: begin
                n_shift = {r_shift[ADC_BITS-2:0], i_data_pin};
                n_bits  = bits_inc;
                n_clk   = 1'b1;
                n_phase = (bits_inc >= LAST_BIT) ? P_END_HIGH : P_BIT_HIGH;
            end
            P_END_HIGH: begin
                n_clk   = 1'b0;
                n_phase = P_END_LOW;
            end
            P_END_LOW: begin
                if (!r_ready) begin
                    // settle conversion, thrown away
                    if (r_settle != '0) begin
                        n_settle = r_settle - CNT_W'(1);
                    end
                    if (r_settle <= CNT_W'(1)) begin
                        n_ready = 1'b1;
                    end
                    n_clk   = 1'b0;
                    n_wait  = '0;
                    n_bits  = '0;
                    n_shift = '0;
                    n_phase = P_WAIT;
                end else begin
                    n_sum  = sum_add;
                    n_good = good_inc;
                    if (good_inc >= r_wanted) begin
                        n_phase     = P_IDLE;
                        n_clk       = 1'b0;
                        res.div_go  = 1'b1;
                        res.div_sum = sum_add;
                        res.div_cnt = good_inc;
                    end else begin
                        n_clk   = 1'b0;
                        n_wait  = '0;
                        n_bits  = '0;
                        n_shift = '0;
                        n_phase = P_WAIT;
                    end
                end
            end
            default: begin
                n_phase = P_IDLE;
                n_clk   = 1'b0;
            end
        endcase
        res.clock_pin = n_clk;
        res.busy      = (n_phase != P_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= P_IDLE;
            r_bits   <= '0;
            r_shift  <= '0;
            r_sum    <= '0;
            r_good   <= '0;
            r_wanted <= '0;
            r_settle <= '0;
            r_wait   <= '0;
            r_ready  <= 1'b0;
            r_clk    <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_bits   <= n_bits;
            r_shift  <= n_shift;
            r_sum    <= n_sum;
            r_good   <= n_good;
            r_wanted <= n_wanted;
            r_settle <= n_settle;
            r_wait   <= n_wait;
            r_ready  <= n_ready;
            r_clk    <= n_clk;
        end
    end

    assign o_res = res;

endmodule

`default_nettype wire

>>> rtl/core/bridge_adc_serial_reader_avg.sv
// top level of the tick-driven bridge adc reader with averaging
`timescale 1ns / 1ps
`default_nettype none

// Reads a two-wire 24-bit bridge converter one half-bit tick at a time. Each
// input word is one tick (action, sample count, data pin level) and gives
// exactly one output word with the serial clock level to drive for that tick,
// busy, and on the completing tick done, success and the signed average. A
// start command runs the power-down and settle sequence first if the
// converter is not initialised, then averages the requested conversions
// (count 0 means 1). For an ordinary tick the word is accepted and its result
// sits in the output register at the next edge. The tick that completes an
// averaged read hands the sum to a shared restoring divider that retires one
// quotient bit per cycle, and o_stall stays high until that result is in the
// output register. A new word is taken while the previous result is still
// waiting, as long as that result is being taken in the same cycle. The user
// must write the configuration registers through the plain write port only
// while the block is idle; the block itself does not enforce this.
module bridge_adc_serial_reader_avg #(
    parameter int ADC_BITS = 24
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [bdsr_pkg::IDX_W-1:0]         i_cfg_idx,
    input  wire logic [bdsr_pkg::TICK_W-1:0]        i_cfg_data,
    // tick words in
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [bdsr_pkg::ACT_W-1:0]         i_action,
    input  wire logic [bdsr_pkg::CNT_W-1:0]         i_sample_count,
    input  wire logic                               i_data_pin,
    // result words out
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic                                    o_clock_pin,
    output logic                                    o_busy_res,
    output logic                                    o_done_res,
    output logic                                    o_success,
    output logic signed [bdsr_pkg::AVG_W-1:0]       o_average
);

    localparam int AVG_W = bdsr_pkg::AVG_W;
    localparam int CNT_W = bdsr_pkg::CNT_W;

    bdsr_pkg::t_cfg       r_cfg;
    bdsr_pkg::t_tick_res  tick_res;

    logic                 accept;
    logic                 div_start;
    logic                 div_busy;
    logic                 div_done;
    logic [AVG_W-1:0]     div_quot;

    // output register
    logic                 r_out_valid;
    logic                 r_clock_pin;
    logic                 r_busy_res;
    logic                 r_done_res;
    logic                 r_success;
    logic [AVG_W-1:0]     r_average;

    // hold off new ticks while the divider runs or the result is blocked
    assign o_stall   = div_busy | (r_out_valid & i_stall);
    assign accept    = i_valid & ~o_stall;
    assign div_start = accept & tick_res.div_go;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout  <= bdsr_pkg::RST_TIMEOUT;
            r_cfg.settle   <= bdsr_pkg::RST_SETTLE;
            r_cfg.rst_high <= bdsr_pkg::RST_RST_HIGH;
            r_cfg.rst_low  <= bdsr_pkg::RST_RST_LOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bdsr_pkg::CFG_TIMEOUT:  r_cfg.timeout  <= i_cfg_data;
                bdsr_pkg::CFG_SETTLE:   r_cfg.settle   <= i_cfg_data[CNT_W-1:0];
                bdsr_pkg::CFG_RST_HIGH: r_cfg.rst_high <= i_cfg_data;
                bdsr_pkg::CFG_RST_LOW:  r_cfg.rst_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-tick sequencer, steps once per accepted word
    bdsr_seq #(
        .ADC_BITS (ADC_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (accept),
        .i_action       (i_action),
        .i_sample_count (i_sample_count),
        .i_data_pin     (i_data_pin),
        .i_cfg          (r_cfg),
        .o_res          (tick_res)
    );

    // shared divider for the final average
    bdsr_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_sum     (tick_res.div_sum),
        .i_divisor (tick_res.div_cnt),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // result word: straight from the tick, or from the divider when it ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((accept && !tick_res.div_go) || div_done) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end

        if (accept && !tick_res.div_go) begin
            r_clock_pin <= tick_res.clock_pin;
            r_busy_res  <= tick_res.busy;
            r_done_res  <= tick_res.done;
            r_success   <= tick_res.success;
            r_average   <= '0;
        end else if (div_done) begin
            // averaged read complete: clock low, idle
            r_clock_pin <= 1'b0;
            r_busy_res  <= 1'b0;
            r_done_res  <= 1'b1;
            r_success   <= 1'b1;
            r_average   <= div_quot;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_clock_pin = r_clock_pin;
    assign o_busy_res  = r_busy_res;
    assign o_done_res  = r_done_res;
    assign o_success   = r_success;
    assign o_average   = $signed(r_average);

endmodule

`default_nettype wire

>>> rtl/core/bdsr_chk.sv
// port-level checks for the bridge adc reader, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bdsr_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic                          o_clock_pin,
    input wire logic                          o_busy_res,
    input wire logic                          o_done_res,
    input wire logic                          o_success,
    input wire logic [bdsr_pkg::AVG_W-1:0]    o_average
);

    // a blocked result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_average) && $stable(o_done_res)
            && $stable(o_success))
        else $error("blocked result word changed");

    // no new tick while the result word is blocked
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("tick taken while result blocked");

    // a completed sequence leaves the clock low and the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_clock_pin && !o_busy_res)
        else $error("completion with clock high or still busy");

    // success and average only on completion
    a_quiet_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> !o_success && (o_average == '0))
        else $error("success or average set without completion");

endmodule

bind bridge_adc_serial_reader_avg bdsr_chk u_bdsr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_clock_pin (o_clock_pin),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_success   (o_success),
    .o_average   (o_average)
);

`default_nettype wire

>>> tb/tb_top.sv
// testbench for the tick-driven bridge adc reader with averaging
`timescale 1ns / 1ps

module tb_top;

    localparam int ACT_W  = bdsr_pkg::ACT_W;
    localparam int CNT_W  = bdsr_pkg::CNT_W;
    localparam int IDX_W  = bdsr_pkg::IDX_W;
    localparam int TICK_W = bdsr_pkg::TICK_W;
    localparam int SUM_W  = bdsr_pkg::SUM_W;
    localparam int AVG_W  = bdsr_pkg::AVG_W;

    localparam int CONV_BITS      = 24;    // bits per conversion
    localparam int HALF_PERIOD    = 5;
    localparam int HOLD_CYCLES    = 40;    // long output hold-off
    localparam int TAIL_CYCLES    = 40;    // lets the divider finish
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving
    localparam int RANDOM_WORDS   = 60;    // tick words under the random setting

    // spare action code, behaves like a plain tick
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    // sequencer phases of the shadow copy
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_HIGH,
        PH_RST_LOW,
        PH_WAIT,
        PH_BIT_HIGH,
        PH_BIT_LOW,
        PH_END_HIGH,
        PH_END_LOW
    } t_seq_phase;

    // one output word of the block
    typedef struct packed {
        logic             clock_pin;
        logic             busy;
        logic             done;
        logic             success;
        logic [AVG_W-1:0] average;
    } t_adc_tick_res;

    // shadow copy of the reader: works out the output word of every accepted
    // tick and keeps the words still owed by the block
    class t_adc_reader_shadow;
        // register copies
        logic [TICK_W-1:0] cfg_timeout;
        logic [CNT_W-1:0]  cfg_settle;
        logic [TICK_W-1:0] cfg_rst_high;
        logic [TICK_W-1:0] cfg_rst_low;
        // sequencer copy
        t_seq_phase        phase;
        logic [4:0]        bit_cnt;
        logic [23:0]       shift_reg;
        logic [SUM_W-1:0]  acc;
        logic [CNT_W-1:0]  good;
        logic [CNT_W-1:0]  wanted;
        logic [CNT_W-1:0]  settle_left;
        logic [TICK_W-1:0] wait_cnt;
        logic              ready;
        logic              clk_lvl;
        t_adc_tick_res     this_tick;
        t_adc_tick_res     owed_outputs[$];
        int                mismatches;
        int                checked;
        int                reads_ok;
        int                reads_failed;
        int                resets_done;

        function new();
            cfg_timeout  = bdsr_pkg::RST_TIMEOUT;
            cfg_settle   = bdsr_pkg::RST_SETTLE;
            cfg_rst_high = bdsr_pkg::RST_RST_HIGH;
            cfg_rst_low  = bdsr_pkg::RST_RST_LOW;
            phase        = PH_IDLE;
            bit_cnt      = '0;
            shift_reg    = '0;
            acc          = '0;
            good         = '0;
            wanted       = '0;
            settle_left  = '0;
            wait_cnt     = '0;
            ready        = 1'b0;
            clk_lvl      = 1'b0;
            mismatches   = 0;
            checked      = 0;
            reads_ok     = 0;
            reads_failed = 0;
            resets_done  = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [TICK_W-1:0] val);
            case (idx)
                bdsr_pkg::CFG_TIMEOUT:  cfg_timeout  = val;
                bdsr_pkg::CFG_SETTLE:   cfg_settle   = val[CNT_W-1:0];
                bdsr_pkg::CFG_RST_HIGH: cfg_rst_high = val;
                bdsr_pkg::CFG_RST_LOW:  cfg_rst_low  = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_outputs.size();
        endfunction

        function void close_sequence(logic ok, logic [AVG_W-1:0] avg);
            phase             = PH_IDLE;
            clk_lvl           = 1'b0;
            this_tick.done    = 1'b1;
            this_tick.success = ok;
            this_tick.average = avg;
            if (!ok) begin
                reads_failed++;
            end else if (wanted == 0) begin
                resets_done++;
            end else begin
                reads_ok++;
            end
        endfunction

        function void start_conversion();
            clk_lvl   = 1'b0;
            wait_cnt  = '0;
            bit_cnt   = '0;
            shift_reg = '0;
            phase     = PH_WAIT;
        endfunction

        // power-down pulse; a count of zero marks a forced reset
        function void start_powerdown(logic [CNT_W-1:0] n);
            ready       = 1'b0;
            wanted      = n;
            good        = '0;
            acc         = '0;
            settle_left = '0;
            clk_lvl     = 1'b1;
            wait_cnt    = 1;
            phase       = PH_RST_HIGH;
        endfunction

        // signed divide truncating toward zero over the good conversions
        function void close_average();
            logic             neg;
            logic [SUM_W-1:0] mag;
            logic [SUM_W-1:0] quo;
            if (good == 0) begin
                ready = 1'b0;
                close_sequence(1'b0, '0);
                return;
            end
            neg = acc[SUM_W-1];
            mag = neg ? (32'd0 - acc) : acc;
            quo = mag / {24'd0, good};
            quo = neg ? (32'd0 - quo) : quo;
            close_sequence(1'b1, quo[AVG_W-1:0]);
        endfunction

        function void end_conversion();
            logic [SUM_W-1:0] raw;
            raw = {{(SUM_W - 24){shift_reg[23]}}, shift_reg};
            // settle conversions are thrown away
            if (!ready) begin
                if (settle_left > 0) settle_left--;
                if (settle_left == 0) ready = 1'b1;
                start_conversion();
                return;
            end
            acc  = acc + raw;
            good = good + 1'b1;
            if (good >= wanted) begin
                close_average();
            end else begin
                start_conversion();
            end
        endfunction

        function void accept_tick(logic [ACT_W-1:0] act, logic [CNT_W-1:0] cnt, logic pin);
            logic [CNT_W-1:0] n;
            this_tick = '0;
            case (phase)
                PH_IDLE: begin
                    if (act == bdsr_pkg::ACT_START) begin
                        n = (cnt == 0) ? 8'd1 : cnt;
                        if (!ready) begin
                            start_powerdown(n);
                        end else begin
                            wanted = n;
                            good   = '0;
                            acc    = '0;
                            start_conversion();
                        end
                    end else if (act == bdsr_pkg::ACT_RESET) begin
                        start_powerdown('0);
                    end
                end
                PH_RST_HIGH: begin
                    if (wait_cnt >= cfg_rst_high) begin
                        clk_lvl  = 1'b0;
                        wait_cnt = '0;
                        phase    = PH_RST_LOW;
                    end else begin
                        wait_cnt++;
                    end
                end
                PH_RST_LOW: begin
                    if (wait_cnt >= cfg_rst_low) begin
                        if (wanted == 0) begin
                            close_sequence(1'b1, '0);
                        end else begin
                            settle_left = cfg_settle;
                            if (settle_left == 0) ready = 1'b1;
                            start_conversion();
                        end
                    end else begin
                        wait_cnt++;
                    end
                end
                PH_WAIT: begin
                    if (!pin) begin
                        clk_lvl = 1'b1;
                        phase   = PH_BIT_HIGH;
                    end else begin
                        wait_cnt++;
                        if (wait_cnt >= cfg_timeout) begin
                            if (!ready) begin
                                close_sequence(1'b0, '0);
                            end else begin
                                close_average();
                            end
                        end
                    end
                end
                PH_BIT_HIGH: begin
                    clk_lvl = 1'b0;
                    phase   = PH_BIT_LOW;
                end
                PH_BIT_LOW: begin
                    shift_reg = {shift_reg[22:0], pin};
                    bit_cnt++;
                    clk_lvl = 1'b1;
                    phase   = (bit_cnt >= CONV_BITS) ? PH_END_HIGH : PH_BIT_HIGH;
                end
                PH_END_HIGH: begin
                    clk_lvl = 1'b0;
                    phase   = PH_END_LOW;
                end
                PH_END_LOW: begin
                    end_conversion();
                end
                default: begin
                    phase   = PH_IDLE;
                    clk_lvl = 1'b0;
                end
            endcase
            this_tick.clock_pin = clk_lvl;
            this_tick.busy      = (phase != PH_IDLE);
            owed_outputs.push_back(this_tick);
        endfunction

        task report_mismatch(string what, logic [AVG_W-1:0] got, logic [AVG_W-1:0] want);
            $display("word %0d: %s got %h expected %h", checked, what, got, want);
            mismatches++;
        endtask

        task compare_field(string what, logic [AVG_W-1:0] got, logic [AVG_W-1:0] want);
            if (got !== want) report_mismatch(what, got, want);
        endtask

        task match_output(t_adc_tick_res got);
            t_adc_tick_res want;
            if (owed_outputs.size() == 0) begin
                report_mismatch("output word with nothing owed", got.average, '0);
                return;
            end
            want = owed_outputs.pop_front();
            compare_field("clock_pin", got.clock_pin, want.clock_pin);
            compare_field("busy_res", got.busy, want.busy);
            compare_field("done_res", got.done, want.done);
            compare_field("success", got.success, want.success);
            compare_field("average", got.average, want.average);
            checked++;
        endtask
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [IDX_W-1:0]         i_cfg_idx;
    logic [TICK_W-1:0]        i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic [ACT_W-1:0]         i_action;
    logic [CNT_W-1:0]         i_sample_count;
    logic                     i_data_pin;
    logic                     o_valid;
    logic                     i_stall;
    logic                     o_clock_pin;
    logic                     o_busy_res;
    logic                     o_done_res;
    logic                     o_success;
    logic signed [AVG_W-1:0]  o_average;

    t_adc_reader_shadow shadow = new();

    // knobs of the converter stand-in and of the idling
    int          pin_high_pct = 30;   // chance of a high pin per ready-wait tick
    int          noise_pct    = 10;   // chance of a stray command while busy
    int          starve_after = -1;   // hold the pin high once this many reads are good
    int          word_sel     = 0;    // 0 mixed, 1 max positive, 2 max negative
    logic [23:0] conv_word    = '0;   // word the converter shifts out next
    bit          quiet_tail   = 1'b0; // no idling on either side
    bit          hold_req     = 1'b0; // ask the result side for a long hold-off
    int          words_sent   = 0;
    int          settings_used = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    bridge_adc_serial_reader_avg #(
        .ADC_BITS(CONV_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_sample_count (i_sample_count),
        .i_data_pin     (i_data_pin),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_clock_pin    (o_clock_pin),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_success      (o_success),
        .o_average      (o_average)
    );

    // conversion words: the extremes, all ones, zero, small signed and random
    function automatic logic [23:0] pick_word();
        logic [23:0] small_val;
        int          sel;
        small_val = 24'($urandom_range(16)) - 24'd8;
        sel = (word_sel != 0) ? word_sel : $urandom_range(1, 8);
        case (sel)
            1:       return 24'h7FFFFF;
            2:       return 24'h800000;
            3:       return 24'h000000;
            4:       return 24'hFFFFFF;
            5, 6:    return small_val;
            default: return 24'($urandom);
        endcase
    endfunction

    // converter stand-in: picks the data pin from where the reader is
    function automatic logic converter_pin();
        case (shadow.phase)
            PH_WAIT: begin
                conv_word = pick_word();
                // starving the pin runs the ready wait into its timeout
                if (starve_after >= 0 && shadow.good >= starve_after) return 1'b1;
                return ($urandom_range(99) < pin_high_pct);
            end
            PH_BIT_LOW: return conv_word[CONV_BITS - 1 - shadow.bit_cnt];
            default:    return 1'($urandom_range(1));
        endcase
    endfunction

    // called at a rising edge; returns at the edge that takes the word
    task automatic send_word(input logic [ACT_W-1:0] act, input logic [CNT_W-1:0] cnt,
                             input logic pin);
        int gap;
        gap = 0;
        if (!quiet_tail && $urandom_range(99) < 12) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_sample_count <= cnt;
        i_data_pin     <= pin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        shadow.accept_tick(act, cnt, pin);
        words_sent++;
    endtask

    // one tick while a sequence runs, now and then with a stray command
    task automatic step_tick();
        logic [ACT_W-1:0] act;
        act = bdsr_pkg::ACT_TICK;
        if ($urandom_range(99) < noise_pct) act = ACT_W'($urandom_range(3));
        send_word(act, CNT_W'($urandom), converter_pin());
    endtask

    // issue one command and tick until the reader is idle again
    task automatic run_cmd(input logic [ACT_W-1:0] act, input logic [CNT_W-1:0] cnt);
        send_word(act, cnt, 1'($urandom_range(1)));
        while (shadow.phase != PH_IDLE) step_tick();
    endtask

    // sender pauses until every owed word has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (shadow.pending() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        shadow.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [TICK_W-1:0] timeout, input logic [TICK_W-1:0] settle,
                              input logic [TICK_W-1:0] hi, input logic [TICK_W-1:0] lo);
        write_reg(bdsr_pkg::CFG_TIMEOUT, timeout);
        write_reg(bdsr_pkg::CFG_SETTLE, settle);
        write_reg(bdsr_pkg::CFG_RST_HIGH, hi);
        write_reg(bdsr_pkg::CFG_RST_LOW, lo);
        settings_used++;
    endtask

    // random command with small counts; large counts get a starved pin so
    // the sequence ends early on a timeout
    task automatic random_cmd();
        int               pick;
        logic [CNT_W-1:0] cnt;
        pick         = $urandom_range(99);
        word_sel     = 0;
        pin_high_pct = $urandom_range(10, 45);
        noise_pct    = $urandom_range(0, 20);
        starve_after = ($urandom_range(9) == 0) ? $urandom_range(1) : -1;
        cnt          = CNT_W'($urandom_range(1, 2));
        if ($urandom_range(19) == 0) cnt = '0;
        if ($urandom_range(19) == 0) begin
            cnt          = CNT_W'($urandom_range(5, 255));
            starve_after = $urandom_range(1);
        end
        if (pick < 70) begin
            run_cmd(bdsr_pkg::ACT_START, cnt);
        end else if (pick < 85) begin
            run_cmd(bdsr_pkg::ACT_RESET, CNT_W'($urandom));
        end else begin
            run_cmd($urandom_range(1) ? bdsr_pkg::ACT_TICK : ACT_SPARE, CNT_W'($urandom));
        end
    endtask

    // result side: check every taken word, stall in short bursts, and hold
    // off for a long stretch when asked
    initial begin : result_sink
        t_adc_tick_res got;
        int            burst_left;
        int            hold_left;
        burst_left = 0;
        hold_left  = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got.clock_pin = o_clock_pin;
                got.busy      = o_busy_res;
                got.done      = o_done_res;
                got.success   = o_success;
                got.average   = o_average;
                shadow.match_output(got);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_stall <= 1'b1;
            end else if (!quiet_tail && $urandom_range(99) < 15) begin
                burst_left = $urandom_range(2);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ends the run when no word moves on either side for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int first_word;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_action       <= bdsr_pkg::ACT_TICK;
        i_sample_count <= '0;
        i_data_pin     <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= bdsr_pkg::CFG_TIMEOUT;
        i_cfg_data     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short timing so that power-down, settle and timeouts all show up
        write_regs(24'd5, 24'd2, 24'd2, 24'd1);

        // idle plain tick and the spare action code
        run_cmd(bdsr_pkg::ACT_TICK, '0);
        run_cmd(ACT_SPARE, 8'hFF);
        // first start: power-down, settle conversions, count zero taken as one
        run_cmd(bdsr_pkg::ACT_START, '0);
        // full-scale positive word
        word_sel = 1;
        run_cmd(bdsr_pkg::ACT_START, 8'd1);
        word_sel = 0;
        // long request of mixed words cut short by a timeout after two good reads
        starve_after = 2;
        run_cmd(bdsr_pkg::ACT_START, 8'hFF);
        // timeout with no good read clears the ready flag
        starve_after = 0;
        run_cmd(bdsr_pkg::ACT_START, 8'd1);
        // so the next start fails during initialization
        run_cmd(bdsr_pkg::ACT_START, 8'd1);
        starve_after = -1;
        // forced reset completes with success and zero average
        run_cmd(bdsr_pkg::ACT_RESET, 8'h5A);

        // zero settle, zero-length power-down, timeout of one and of zero
        wait_drained();
        write_regs(24'd1, 24'd0, 24'd0, 24'd0);
        pin_high_pct = 40;
        run_cmd(bdsr_pkg::ACT_START, 8'd1);
        wait_drained();
        write_regs(24'd0, 24'd0, 24'd1, 24'd0);
        run_cmd(bdsr_pkg::ACT_START, 8'd1);
        // clean read leaves the converter initialized for the next setting
        pin_high_pct = 0;
        run_cmd(bdsr_pkg::ACT_START, 8'd1);

        // register maxima; the reader stays initialized, so no power-down runs
        wait_drained();
        write_regs(24'hFFFFFF, 24'hFF, 24'hFFFFFF, 24'hFFFFFF);
        pin_high_pct = 50;
        noise_pct    = 20;
        word_sel     = 2;
        run_cmd(bdsr_pkg::ACT_START, 8'd1);
        word_sel = 0;

        // random commands under a random setting; the last part runs
        // without idling on either side
        wait_drained();
        write_regs(TICK_W'($urandom_range(1, 8)), TICK_W'($urandom_range(0, 2)),
                   TICK_W'($urandom_range(1, 4)), TICK_W'($urandom_range(0, 4)));
        // long hold-off on the result side while ticks keep coming
        hold_req   = 1'b1;
        first_word = words_sent;
        while (words_sent - first_word < RANDOM_WORDS) begin
            if (words_sent - first_word >= RANDOM_WORDS / 2) quiet_tail = 1'b1;
            random_cmd();
            if (!quiet_tail && $urandom_range(9) == 0) wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d tick words sent under %0d register settings, %0d output words checked",
                 words_sent, settings_used, shadow.checked);
        $display("%0d averaged reads, %0d failed sequences, %0d forced resets completed",
                 shadow.reads_ok, shadow.reads_failed, shadow.resets_done);
        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bdsr_pkg.sv
rtl/core/bdsr_div.sv
rtl/core/bdsr_seq.sv
rtl/core/bridge_adc_serial_reader_avg.sv
rtl/core/bdsr_chk.sv
tb/tb_top.sv
